>>> rtl/tst_pkg.sv
// Package for the topic subscription table: sizes, codes, payload structs,
// state encoding and controller/datapath command and status structs.
// No dependencies.
package tst_pkg;

  localparam int TOPIC_SLOTS = 8;
  localparam int PUB_DEPTH   = 8;
  localparam int SUB_DEPTH   = 16;
  localparam int NAME_BYTES  = 8;

  localparam int SLOT_W  = $clog2(TOPIC_SLOTS);
  localparam int PUB_W   = $clog2(PUB_DEPTH);
  localparam int SUB_W   = $clog2(SUB_DEPTH);
  localparam int PCNT_W  = $clog2(PUB_DEPTH + 1);
  localparam int SCNT_W  = $clog2(SUB_DEPTH + 1);
  localparam int SCAN_W  = $clog2(TOPIC_SLOTS + 1);
  localparam int PADDR_W = $clog2(TOPIC_SLOTS * PUB_DEPTH);
  localparam int SADDR_W = $clog2(TOPIC_SLOTS * SUB_DEPTH);
  localparam int ENT_W   = 48;

  typedef enum logic [2:0] {
    MODE_ADD_SUB = 3'd0,
    MODE_ADD_PUB = 3'd1,
    MODE_REM_SUB = 3'd2,
    MODE_REM_PUB = 3'd3,
    MODE_NEW     = 3'd4,
    MODE_DROP    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOTOPIC   = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_TABLEFULL = 3'd3,
    ST_LISTFULL  = 3'd4,
    ST_NOID      = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] name_bytes;
    logic [15:0] handle;
    logic [31:0] client_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] assigned_id;
    logic [2:0]  topic_slot;
    logic        released_valid;
    logic [15:0] released_handle;
    logic        topic_removed;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FIND_RD,
    S_FIND_CHK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_REM_END,
    S_DROP_RD,
    S_DROP_OUT,
    S_EMIT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the input item
    logic scan_clr;   // restart the slot scan
    logic scan_step;  // examine one slot
    logic decide;     // settle add/new/remove action, stage a single result
    logic idx_clr;    // clear list index
    logic idx_inc;    // advance list index
    logic rd_issue;   // read entry at index (index+1 when move)
    logic id_chk;     // compare the read entry with the client id
    logic move;       // read the following entry for compaction
    logic move_wr;    // write moved entry at index
    logic rem_end;    // finish a client removal
    logic drop_out;   // stage a release result from the read entry
    logic drop_empty; // stage the single result of an empty drop
    logic out_load;   // make the staged result visible
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;
    logic remove_mode;
    logic drop_mode;
    logic topic_found;
    logic idx_at_end;   // index reached list count
    logic move_at_end;  // index+1 reached list count
    logic id_match;
    logic drop_empty;
    logic drop_at_end;  // drop walk consumed all entries
    logic out_busy;
    logic ignore;
  } stat_t;

endpackage

>>> rtl/tst_ctrl.sv
// Controller state machine for the topic subscription table.
// Depends on tst_pkg.
module tst_ctrl import tst_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_SCAN;
      S_SCAN:     if (st.scan_done) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (st.ignore) state_nxt = S_IDLE;
        else if (st.remove_mode && st.topic_found) state_nxt = S_FIND_RD;
        else if (st.drop_mode && st.topic_found) begin
          if (st.drop_empty) state_nxt = S_EMIT;
          else state_nxt = S_DROP_RD;
        end else state_nxt = S_EMIT;
      end
      S_FIND_RD: begin
        if (st.idx_at_end) state_nxt = S_REM_END;
        else state_nxt = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        if (st.id_match) state_nxt = S_MOVE_RD;
        else state_nxt = S_FIND_RD;
      end
      S_MOVE_RD: begin
        if (st.move_at_end) state_nxt = S_REM_END;
        else state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR:  state_nxt = S_MOVE_RD;
      S_REM_END:  state_nxt = S_EMIT;
      S_DROP_RD: begin
        if (!st.out_busy) state_nxt = S_DROP_OUT;
      end
      S_DROP_OUT: state_nxt = st.drop_at_end ? S_EMIT : S_DROP_RD;
      S_EMIT:     if (!st.out_busy) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load     = in_valid;
        cmd.scan_clr = in_valid;
      end
      S_SCAN:     cmd.scan_step = 1'b1;
      S_DECIDE: begin
        cmd.decide     = 1'b1;
        cmd.idx_clr    = 1'b1;
        cmd.drop_empty = st.drop_mode && st.topic_found && st.drop_empty;
      end
      S_FIND_RD:  cmd.rd_issue = !st.idx_at_end;
      S_FIND_CHK: begin
        cmd.id_chk  = 1'b1;
        cmd.idx_inc = !st.id_match;
      end
      S_MOVE_RD: begin
        cmd.rd_issue = !st.move_at_end;
        cmd.move     = 1'b1;
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      S_REM_END:  cmd.rem_end = 1'b1;
      S_DROP_RD:  cmd.rd_issue = !st.out_busy;
      S_DROP_OUT: begin
        cmd.drop_out = 1'b1;
        cmd.idx_inc  = 1'b1;
        cmd.out_load = !st.drop_at_end;
      end
      S_EMIT:     cmd.out_load = !st.out_busy;
      default:    cmd = '0;
    endcase
  end

endmodule

>>> rtl/tst_dp.sv
// Datapath for the topic subscription table: slot table, list memories,
// id counter, slot scan, list walk and the output register.
// Depends on tst_pkg.
module tst_dp import tst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output stat_t     st,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [TOPIC_SLOTS-1:0] slot_valid_r;
  logic [63:0]            slot_name_r [TOPIC_SLOTS];
  logic [SCNT_W-1:0]      sub_count_r [TOPIC_SLOTS];
  logic [PCNT_W-1:0]      pub_count_r [TOPIC_SLOTS];
  logic [ENT_W-1:0]       sub_mem [TOPIC_SLOTS*SUB_DEPTH];
  logic [ENT_W-1:0]       pub_mem [TOPIC_SLOTS*PUB_DEPTH];
  logic [31:0]            next_id_r;

  logic [2:0]        mode_r;
  logic [63:0]       name_r;
  logic [15:0]       handle_r;
  logic [31:0]       cid_r;
  logic [SCAN_W-1:0] scan_r;
  logic              found_r, free_ok_r;
  logic [SLOT_W-1:0] found_slot_r, free_slot_r, slot_r;
  logic [SCNT_W:0]   idx_r;
  logic              found_id_r;
  logic [15:0]       rel_h_r;
  logic [ENT_W-1:0]  rd_r;
  out_item_t         stage_r, stage_nxt;
  logic              out_valid_r;
  out_item_t         out_r, out_nxt;

  // normalize: bytes after the first zero byte count as zero
  logic [63:0] norm;
  always_comb begin
    logic stop;
    norm = '0;
    stop = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (in_data.name_bytes[8*b +: 8] == 8'd0) stop = 1'b1;
      if (!stop) norm[8*b +: 8] = in_data.name_bytes[8*b +: 8];
    end
  end

  logic is_sub, is_add, is_rem, is_drop, is_new;
  assign is_sub  = (mode_r == MODE_ADD_SUB) || (mode_r == MODE_REM_SUB);
  assign is_add  = (mode_r == MODE_ADD_SUB) || (mode_r == MODE_ADD_PUB);
  assign is_rem  = (mode_r == MODE_REM_SUB) || (mode_r == MODE_REM_PUB);
  assign is_drop = (mode_r == MODE_DROP);
  assign is_new  = (mode_r == MODE_NEW);

  logic [SLOT_W-1:0] scan_idx;
  assign scan_idx = scan_r[SLOT_W-1:0];

  logic [SCNT_W-1:0] cur_sc;
  logic [PCNT_W-1:0] cur_pc;
  logic [SCNT_W:0]   cur_cnt, total;
  assign cur_sc  = sub_count_r[slot_r];
  assign cur_pc  = pub_count_r[slot_r];
  assign cur_cnt = is_sub ? (SCNT_W+1)'(cur_sc) : (SCNT_W+1)'(cur_pc);
  assign total   = (SCNT_W+1)'(cur_sc) + (SCNT_W+1)'(cur_pc);

  logic [SLOT_W-1:0] dec_slot;
  assign dec_slot = found_r ? found_slot_r : free_slot_r;

  logic [SCNT_W:0] rd_idx;
  assign rd_idx = cmd.move ? idx_r + 1'b1 : idx_r;

  // drop walk: index runs over publishers then subscribers
  logic drop_pub;
  assign drop_pub = idx_r < (SCNT_W+1)'(cur_pc);
  logic [SCNT_W:0] sidx;
  assign sidx = idx_r - (SCNT_W+1)'(cur_pc);

  logic [PADDR_W-1:0] p_rd_addr, p_wr_addr;
  logic [SADDR_W-1:0] s_rd_addr, s_wr_addr;
  always_comb begin
    if (is_drop) begin
      p_rd_addr = PADDR_W'({slot_r, idx_r[PUB_W-1:0]});
      s_rd_addr = SADDR_W'({slot_r, sidx[SUB_W-1:0]});
    end else begin
      p_rd_addr = PADDR_W'({slot_r, rd_idx[PUB_W-1:0]});
      s_rd_addr = SADDR_W'({slot_r, rd_idx[SUB_W-1:0]});
    end
  end

  logic              add_ok;
  logic [SLOT_W-1:0] add_slot;
  assign add_slot = dec_slot;
  assign add_ok = is_add && (found_r || free_ok_r) &&
                  ((mode_r == MODE_ADD_SUB) ?
                   ((found_r ? (SCNT_W+1)'(sub_count_r[dec_slot]) : '0) <
                    (SCNT_W+1)'(SUB_DEPTH)) :
                   ((found_r ? (SCNT_W+1)'(pub_count_r[dec_slot]) : '0) <
                    (SCNT_W+1)'(PUB_DEPTH)));
  logic [SCNT_W-1:0] add_sc;
  logic [PCNT_W-1:0] add_pc;
  assign add_sc = found_r ? sub_count_r[dec_slot] : '0;
  assign add_pc = found_r ? pub_count_r[dec_slot] : '0;
  assign p_wr_addr = cmd.decide ? PADDR_W'({add_slot, add_pc[PUB_W-1:0]})
                                : PADDR_W'({slot_r, idx_r[PUB_W-1:0]});
  assign s_wr_addr = cmd.decide ? SADDR_W'({add_slot, add_sc[SUB_W-1:0]})
                                : SADDR_W'({slot_r, idx_r[SUB_W-1:0]});

  logic create;
  assign create = cmd.decide && (is_add || is_new) && !found_r && free_ok_r;

  logic p_we, s_we;
  assign p_we = (cmd.decide && add_ok && !is_sub) || (cmd.move_wr && !is_sub);
  assign s_we = (cmd.decide && add_ok && is_sub) || (cmd.move_wr && is_sub);
  logic [ENT_W-1:0] wr_ent;
  assign wr_ent = cmd.decide ? {next_id_r, handle_r} : rd_r;

  // list memories
  always_ff @(posedge clk) begin
    if (p_we) pub_mem[p_wr_addr] <= wr_ent;
    if (s_we) sub_mem[s_wr_addr] <= wr_ent;
    if (cmd.rd_issue) begin
      rd_r <= (is_drop ? drop_pub : !is_sub) ? pub_mem[p_rd_addr]
                                             : sub_mem[s_rd_addr];
    end
  end

  logic rem_empty;
  always_comb begin
    logic [SCNT_W-1:0] sc;
    logic [PCNT_W-1:0] pc;
    sc = cur_sc;
    pc = cur_pc;
    if (found_id_r) begin
      if (is_sub) sc = sc - 1'b1;
      else pc = pc - 1'b1;
    end
    rem_empty = (sc == '0) && (pc == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_data.mode;
      name_r   <= norm;
      handle_r <= in_data.handle;
      cid_r    <= in_data.client_id;
    end
    if (cmd.scan_clr) begin
      scan_r    <= '0;
      found_r   <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (cmd.scan_step && !st.scan_done) begin
      scan_r <= scan_r + 1'b1;
      if (slot_valid_r[scan_idx] && slot_name_r[scan_idx] == name_r && !found_r) begin
        found_r      <= 1'b1;
        found_slot_r <= scan_idx;
      end
      if (!slot_valid_r[scan_idx] && !free_ok_r) begin
        free_ok_r   <= 1'b1;
        free_slot_r <= scan_idx;
      end
    end
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    if (cmd.decide) begin
      slot_r     <= dec_slot;
      found_id_r <= 1'b0;
      rel_h_r    <= '0;
    end else if (cmd.id_chk && st.id_match && !found_id_r) begin
      found_id_r <= 1'b1;
      rel_h_r    <= rd_r[15:0];
    end
  end

  // slot table and id counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      next_id_r    <= '0;
      for (int i = 0; i < TOPIC_SLOTS; i++) begin
        slot_name_r[i] <= '0;
        sub_count_r[i] <= '0;
        pub_count_r[i] <= '0;
      end
    end else begin
      if (create) begin
        slot_valid_r[free_slot_r] <= 1'b1;
        slot_name_r[free_slot_r]  <= name_r;
      end
      if (create && !add_ok) begin
        sub_count_r[free_slot_r] <= '0;
        pub_count_r[free_slot_r] <= '0;
      end
      if (cmd.decide && add_ok) begin
        next_id_r <= next_id_r + 1'b1;
        if (is_sub) begin
          sub_count_r[add_slot] <= add_sc + 1'b1;
          if (!found_r) pub_count_r[add_slot] <= '0;
        end else begin
          pub_count_r[add_slot] <= add_pc + 1'b1;
          if (!found_r) sub_count_r[add_slot] <= '0;
        end
      end
      if (cmd.rem_end) begin
        if (found_id_r) begin
          if (is_sub) sub_count_r[slot_r] <= cur_sc - 1'b1;
          else pub_count_r[slot_r] <= cur_pc - 1'b1;
        end
        if (rem_empty) begin
          slot_valid_r[slot_r] <= 1'b0;
          slot_name_r[slot_r]  <= '0;
        end
      end
      // an empty drop is settled in the decide cycle, before slot_r loads
      if (is_drop && cmd.drop_empty) begin
        slot_valid_r[found_slot_r] <= 1'b0;
        slot_name_r[found_slot_r]  <= '0;
        sub_count_r[found_slot_r]  <= '0;
        pub_count_r[found_slot_r]  <= '0;
      end
      if (is_drop && cmd.drop_out && st.drop_at_end) begin
        slot_valid_r[slot_r] <= 1'b0;
        slot_name_r[slot_r]  <= '0;
        sub_count_r[slot_r]  <= '0;
        pub_count_r[slot_r]  <= '0;
      end
    end
  end

  // staged result
  always_comb begin
    stage_nxt = stage_r;
    if (cmd.decide) begin
      stage_nxt = '0;
      stage_nxt.last = 1'b1;
      if (is_add || is_new) begin
        if (!found_r && !free_ok_r) stage_nxt.status = ST_TABLEFULL;
        else if (is_new && found_r) begin
          stage_nxt.status     = ST_EXISTS;
          stage_nxt.topic_slot = 3'(dec_slot);
        end else begin
          stage_nxt.topic_slot = 3'(dec_slot);
          if (is_new) stage_nxt.status = ST_OK;
          else if (add_ok) begin
            stage_nxt.status      = ST_OK;
            stage_nxt.assigned_id = next_id_r;
          end else stage_nxt.status = ST_LISTFULL;
        end
      end else if (!found_r) stage_nxt.status = ST_NOTOPIC;
      else begin
        stage_nxt.status        = ST_OK;
        stage_nxt.topic_slot    = 3'(found_slot_r);
        stage_nxt.topic_removed = is_drop;
      end
    end else if (cmd.rem_end) begin
      stage_nxt.status          = found_id_r ? ST_OK : ST_NOID;
      stage_nxt.released_valid  = found_id_r;
      stage_nxt.released_handle = found_id_r ? rel_h_r : 16'd0;
      stage_nxt.topic_removed   = rem_empty;
    end else if (cmd.drop_out) begin
      stage_nxt.released_valid  = 1'b1;
      stage_nxt.released_handle = rd_r[15:0];
      stage_nxt.topic_removed   = 1'b1;
      stage_nxt.last            = st.drop_at_end;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load && !cmd.drop_out) out_valid_r <= 1'b1;
    else if (cmd.drop_out && !st.drop_at_end) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_comb begin
    out_nxt = out_r;
    if (cmd.drop_out && !st.drop_at_end) begin
      out_nxt                 = stage_r;
      out_nxt.status          = ST_OK;
      out_nxt.topic_slot      = 3'(slot_r);
      out_nxt.released_valid  = 1'b1;
      out_nxt.released_handle = rd_r[15:0];
      out_nxt.topic_removed   = 1'b1;
      out_nxt.assigned_id     = '0;
      out_nxt.last            = 1'b0;
    end else if (cmd.out_load) out_nxt = stage_r;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign st.scan_done   = scan_r == SCAN_W'(TOPIC_SLOTS);
  assign st.remove_mode = is_rem;
  assign st.drop_mode   = is_drop;
  assign st.topic_found = found_r;
  assign st.idx_at_end  = idx_r >= cur_cnt;
  assign st.move_at_end = (idx_r + 1'b1) >= cur_cnt;
  assign st.id_match    = rd_r[47:16] == cid_r;
  assign st.drop_empty  = (sub_count_r[found_slot_r] == '0) &&
                          (pub_count_r[found_slot_r] == '0);
  assign st.drop_at_end = (idx_r + 1'b1) >= total;
  assign st.out_busy    = out_valid_r && !out_ready;
  assign st.ignore      = (mode_r == 3'd6) || (mode_r == 3'd7);

endmodule

>>> rtl/topic_subscription_table_core.sv
// Top level of the topic subscription table: joins controller and datapath.
// Depends on tst_pkg, tst_ctrl, tst_dp.
//
// Usage: present one request item on in_data with in_valid; it is taken
// when in_ready is high, which happens only while the block is idle. Each
// item yields one result on out_data/out_valid (valid/ready), except the
// removal of a topic that holds handles, which yields one result per
// released handle (publishers first, then subscribers) with last set on
// the final one. Modes 6 and 7 give no result.
// Sequence: every item first scans all TOPIC_SLOTS slots for its name and
// a free slot, then settles its action and stages a result that is loaded
// into the output register; the next item is taken only after that.
// Removals walk the list, comparing each entry with the client id and then
// shifting the later entries down; a topic removal walks every released
// handle. A full topic removal is the longest item.
// Reset: synchronous active-low rst_n empties the topic table and zeroes
// the id counter; list memories need no clearing.
// Stall: a result waits in the output register while out_ready is low; the
// walk holds until the register drains.
module topic_subscription_table_core import tst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t  cmd;
  stat_t st;

  tst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tst_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
